// ----- rtl/jrhc_pkg.sv -----
// ----------------------------------------------------------------------------
// jrhc_pkg: shared types and constants
// Word formats and codes of the JPEG restart-height checker.
// ----------------------------------------------------------------------------
`default_nettype none
package jrhc_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_HEADER  = 2'd1;
   localparam logic [1:0] ST_PAGE    = 2'd2;
   localparam logic [1:0] ST_ENTROPY = 2'd3;

   localparam logic [0:0] CSR_PAGE_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_PAGE_HEIGHT = 1'b1;

   localparam logic [16:0] POS_SAT = 17'h1FFFF;

   localparam logic [7:0] MK_SOI  = 8'hD8;
   localparam logic [7:0] MK_EOI  = 8'hD9;
   localparam logic [7:0] MK_SOF0 = 8'hC0;
   localparam logic [7:0] MK_DRI  = 8'hDD;
   localparam logic [7:0] MK_SOS  = 8'hDA;
   localparam logic [7:0] MK_RST0 = 8'hD0;
   localparam logic [7:0] MK_FF   = 8'hFF;

   // one input byte with its position, as queued between front and back
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [16:0] pos;
   } byte_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] hdr_height;
      logic [16:0] height_field_offset;
      logic [12:0] sof_width;
   } verdict_type;

endpackage
`default_nettype wire

// ----- rtl/jrhc_front.sv -----
// ----------------------------------------------------------------------------
// jrhc_front: byte intake
// Accept bytes, stamp each with its saturating file position, push to queue.
// ----------------------------------------------------------------------------
`default_nettype none
module jrhc_front
   import jrhc_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire  [7:0]    in_data,
   input  wire           in_last,
   input  wire           in_valid,
   output logic          in_ready,
   output byte_word_type q_word,
   output logic          q_push,
   input  wire           q_full
);
   logic [16:0] pos_ff, pos_in;

   assign in_ready      = !q_full;
   assign q_push        = in_valid && !q_full;
   assign q_word.data   = in_data;
   assign q_word.last   = in_last;
   assign q_word.pos    = pos_ff;

   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (in_last) pos_in = '0;
         else if (pos_ff != POS_SAT) pos_in = pos_ff + 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else pos_ff <= pos_in;
   end
endmodule
`default_nettype wire

// ----- rtl/jrhc_fifo.sv -----
// ----------------------------------------------------------------------------
// jrhc_fifo: small word queue
// Register-based FIFO decoupling intake from the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module jrhc_fifo
   import jrhc_pkg::*;
#(
   parameter int DEPTH_LOG2 = 2
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           push,
   input  byte_word_type push_word,
   output logic          full,
   input  wire           pop,
   output byte_word_type pop_word,
   output logic          empty
);
   localparam int DEPTH = 1 << DEPTH_LOG2;
   byte_word_type mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wp_ff, rp_ff;
   logic [DEPTH_LOG2:0]   cnt_ff;

   assign full     = cnt_ff == (DEPTH_LOG2+1)'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- rtl/jrhc_parser.sv -----
// ----------------------------------------------------------------------------
// jrhc_parser: marker walker and verdict
// Walk header segments and entropy data; produce one verdict per file.
// ----------------------------------------------------------------------------
`default_nettype none
module jrhc_parser
   import jrhc_pkg::*;
#(
   parameter int MAX_SEGMENTS      = 128,
   parameter int HEADER_BYTE_LIMIT = 65536
) (
   input  wire           clock,
   input  wire           reset,
   input  byte_word_type word,
   input  wire           word_valid,
   output logic          word_pop,
   input  wire  [12:0]   pg_width,
   input  wire  [13:0]   pg_height,
   output verdict_type   out_word,
   output logic          out_valid,
   input  wire           out_ready
);
   typedef enum logic [3:0] {
      PH_SOI0, PH_SOI1, PH_SEGFF, PH_MARKER, PH_LENHI, PH_LENLO,
      PH_PAYLOAD, PH_ENTROPY, PH_DRAIN, PH_OK
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  segs_ff, segs_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] left_ff, left_in;
   logic [3:0]  idx_ff, idx_in;
   logic        frame_ff, frame_in, dri_ff, dri_in;
   logic [15:0] ri_ff, ri_in;
   logic [12:0] width_ff, width_in;
   logic [13:0] rows_ff, rows_in;
   logic [16:0] hoff_ff, hoff_in;
   logic [10:0] rst_ff, rst_in;
   logic        pre_ff, pre_in;
   logic [1:0]  verd_ff, verd_in;
   logic [13:0] hgt_ff, hgt_in;
   logic [7:0]  hold_ff, hold_in;
   logic        ov_ff;
   verdict_type ow_ff, ow_in;

   logic        take;
   logic [7:0]  b;
   logic [15:0] v16;
   logic [15:0] len_m2;
   logic        sof_ok, is_rst;
   logic [13:0] h;
   logic [14:0] diff;
   logic [1:0]  status;
   logic [8:0]  ri_want;

   // a waiting verdict holds back only the next final byte
   assign take     = word_valid && (!word.last || !ov_ff || out_ready);
   assign word_pop = take;
   assign b        = word.data;
   assign v16      = {hold_ff, b};
   assign len_m2   = v16 - 16'd2;
   assign is_rst   = b[7:3] == MK_RST0[7:3];
   assign ri_want  = 9'((14'(width_ff) + 14'd15) >> 4);
   assign out_valid = ov_ff;
   assign out_word  = ow_ff;

   always_comb begin
      sof_ok = 1'b1;
      case (idx_ff)
         4'd0:  sof_ok = b == 8'd8;
         4'd1:  sof_ok = word.pos != POS_SAT;
         4'd2:  sof_ok = v16 == 16'd4200 || v16 == 16'd8400;
         4'd4:  sof_ok = (v16 == 16'd2550 && rows_ff == 14'd4200) ||
                         (v16 == 16'd5100 && rows_ff == 14'd8400);
         4'd5:  sof_ok = b == 8'd3;
         4'd6:  sof_ok = b == 8'd1;
         4'd7:  sof_ok = b == 8'h21;
         4'd9:  sof_ok = b == 8'd2;
         4'd10: sof_ok = b == 8'h11;
         4'd12: sof_ok = b == 8'd3;
         4'd13: sof_ok = b == 8'h11;
         default: sof_ok = 1'b1;
      endcase
   end

   always_comb begin
      logic seg_end;
      logic f_n, d_n;
      seg_end = 1'b0;
      phase_in = phase_ff; segs_in = segs_ff; marker_in = marker_ff;
      left_in = left_ff; idx_in = idx_ff; frame_in = frame_ff; dri_in = dri_ff;
      ri_in = ri_ff; width_in = width_ff; rows_in = rows_ff; hoff_in = hoff_ff;
      rst_in = rst_ff; pre_in = pre_ff; verd_in = verd_ff; hgt_in = hgt_ff;
      hold_in = hold_ff;
      h    = 14'((15'(rst_ff) + 15'd1) << 3);
      diff = (15'(h) > 15'(pg_height)) ? 15'(h) - 15'(pg_height)
                                       : 15'(pg_height) - 15'(h);
      case (phase_ff)
         PH_ENTROPY: begin
            if (!pre_ff) pre_in = b == MK_FF;
            else if (b != MK_FF) begin
               pre_in = 1'b0;
               if (b == 8'h00) begin
                  pre_in = 1'b0;
               end else if (is_rst) begin
                  if (14'(rst_ff) >= (rows_ff >> 3) || b[2:0] != rst_ff[2:0]) begin
                     verd_in = ST_ENTROPY; phase_in = PH_DRAIN;
                  end else rst_in = rst_ff + 11'd1;
               end else if (b == MK_EOI && word.last) begin
                  if (h > rows_ff || diff > 15'd8) begin
                     verd_in = ST_ENTROPY; phase_in = PH_DRAIN;
                  end else begin
                     hgt_in = h; phase_in = PH_OK;
                  end
               end else begin
                  verd_in = ST_ENTROPY; phase_in = PH_DRAIN;
               end
            end
         end
         PH_OK: begin
            verd_in = ST_ENTROPY; phase_in = PH_DRAIN;
         end
         PH_DRAIN: phase_in = PH_DRAIN;
         PH_SOI0: begin
            if (b == MK_FF) phase_in = PH_SOI1;
            else begin verd_in = ST_HEADER; phase_in = PH_DRAIN; end
         end
         PH_SOI1: begin
            if (b == MK_SOI) phase_in = PH_SEGFF;
            else begin verd_in = ST_HEADER; phase_in = PH_DRAIN; end
         end
         PH_SEGFF: begin
            if (32'(segs_ff) >= MAX_SEGMENTS || 32'(word.pos) > HEADER_BYTE_LIMIT
                || b != MK_FF) begin
               verd_in = ST_HEADER; phase_in = PH_DRAIN;
            end else begin
               segs_in = segs_ff + 8'd1; phase_in = PH_MARKER;
            end
         end
         PH_MARKER: begin
            if (b != MK_FF) begin
               if (b == 8'h00 || b == MK_SOI || b == MK_EOI || is_rst) begin
                  verd_in = ST_HEADER; phase_in = PH_DRAIN;
               end else begin
                  marker_in = b; phase_in = PH_LENHI;
               end
            end
         end
         PH_LENHI: begin
            hold_in = b; phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            if (v16 < 16'd2 ||
                (marker_ff == MK_SOF0 && (frame_ff || v16 != 16'd17)) ||
                (marker_ff == MK_DRI && (dri_ff || v16 != 16'd4))) begin
               verd_in = ST_HEADER; phase_in = PH_DRAIN;
            end else begin
               left_in = len_m2; idx_in = '0;
               if (len_m2 == '0) seg_end = 1'b1; else phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (marker_ff == MK_SOF0 && !sof_ok) begin
               verd_in = ST_HEADER; phase_in = PH_DRAIN;
            end else begin
               if (marker_ff == MK_SOF0) begin
                  case (idx_ff)
                     4'd1: begin hoff_in = word.pos; hold_in = b; end
                     4'd2: rows_in = 14'(v16);
                     4'd3: hold_in = b;
                     4'd4: width_in = 13'(v16);
                     default: hold_in = hold_ff;
                  endcase
               end else if (marker_ff == MK_DRI) begin
                  if (idx_ff == '0) hold_in = b; else ri_in = v16;
               end
               left_in = left_ff - 16'd1;
               if (idx_ff != 4'd15) idx_in = idx_ff + 4'd1;
               if (left_ff == 16'd1) seg_end = 1'b1;
            end
         end
         default: begin verd_in = ST_HEADER; phase_in = PH_DRAIN; end
      endcase
      if (seg_end) begin
         f_n = frame_ff || marker_ff == MK_SOF0;
         d_n = dri_ff || marker_ff == MK_DRI;
         frame_in = f_n; dri_in = d_n;
         if (marker_ff != MK_SOS) phase_in = PH_SEGFF;
         else if (!f_n || !d_n || ri_in != 16'(ri_want)) begin
            verd_in = ST_HEADER; phase_in = PH_DRAIN;
         end else if (pg_width == '0 || pg_width > 13'd5100 || pg_height == '0
                      || pg_height > 14'd8400 || pg_width > width_in
                      || pg_height > rows_in) begin
            verd_in = ST_PAGE; phase_in = PH_DRAIN;
         end else begin
            phase_in = PH_ENTROPY; rst_in = '0; pre_in = 1'b0;
         end
      end
      case (phase_in)
         PH_DRAIN:   status = verd_in;
         PH_OK:      status = ST_OK;
         PH_ENTROPY: status = ST_ENTROPY;
         default:    status = ST_HEADER;
      endcase
      ow_in.status              = status;
      ow_in.hdr_height          = (status == ST_OK) ? hgt_in : '0;
      ow_in.height_field_offset = (status != ST_HEADER) ? hoff_in : '0;
      ow_in.sof_width           = (status != ST_HEADER) ? width_in : '0;
   end

   always_ff @(posedge clock) begin
      if (take && word.last) ow_ff <= ow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (take && word.last) begin
         ov_ff <= 1'b1;
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && word.last)) begin
         phase_ff <= PH_SOI0; segs_ff <= '0; marker_ff <= '0; left_ff <= '0;
         idx_ff <= '0; frame_ff <= 1'b0; dri_ff <= 1'b0; ri_ff <= '0;
         width_ff <= '0; rows_ff <= '0; hoff_ff <= '0; rst_ff <= '0;
         pre_ff <= 1'b0; verd_ff <= '0; hgt_ff <= '0; hold_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; segs_ff <= segs_in; marker_ff <= marker_in;
         left_ff <= left_in; idx_ff <= idx_in; frame_ff <= frame_in;
         dri_ff <= dri_in; ri_ff <= ri_in; width_ff <= width_in;
         rows_ff <= rows_in; hoff_ff <= hoff_in; rst_ff <= rst_in;
         pre_ff <= pre_in; verd_ff <= verd_in; hgt_ff <= hgt_in;
         hold_ff <= hold_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/jpeg_restart_height_checker.sv -----
// ----------------------------------------------------------------------------
// jpeg_restart_height_checker: baseline JPEG header and restart checker
// Streams a JPEG file one byte per word and returns one verdict per file.
// ----------------------------------------------------------------------------
// Feed the file one byte per req word, with req_tlast on the final byte; the
// block takes one byte per cycle while the queue has room and returns one
// rsp word after each final byte: status, the height (restarts+1)*8 to
// write into the frame header, the byte offset of the SOF0 height field and
// the frame width. An intake stage stamps each byte with its file position
// and queues it; the parser behind the four-entry queue walks one byte per
// cycle while no final byte waits on a held verdict. A verdict is registered
// onto rsp once its final byte has gone through the queue to the parser. A
// verdict that waits on rsp_tready holds back only the next final byte; the
// other bytes keep flowing until the queue fills. Write pg_width (index 0)
// and pg_height (index 1) only while no file is in flight.
`default_nettype none
module jpeg_restart_height_checker
   import jrhc_pkg::*;
#(
   parameter int MAX_SEGMENTS      = 128,
   parameter int HEADER_BYTE_LIMIT = 65536
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] data_byte
   input  wire          req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,   // [1:0] status, [15:2] hdr_height,
                                     // [32:16] height_field_offset,
                                     // [45:33] sof_width, [47:46] zero
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [0:0]   csr_index,
   input  wire  [13:0]  csr_data
);
   byte_word_type push_word, pop_word;
   logic          push, full, pop, empty;
   verdict_type   vw;
   logic [12:0]   pg_width_ff;
   logic [13:0]   pg_height_ff;

   // configuration registers, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pg_width_ff  <= '0;
         pg_height_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAGE_WIDTH:  pg_width_ff  <= csr_data[12:0];
            CSR_PAGE_HEIGHT: pg_height_ff <= csr_data;
            default:         pg_width_ff  <= pg_width_ff;
         endcase
      end
   end

   jrhc_front u_front (
      .clock, .reset,
      .in_data(req_tdata), .in_last(req_tlast), .in_valid(req_tvalid),
      .in_ready(req_tready), .q_word(push_word), .q_push(push), .q_full(full)
   );

   jrhc_fifo #(.DEPTH_LOG2(2)) u_fifo (
      .clock, .reset, .push, .push_word, .full,
      .pop, .pop_word, .empty
   );

   jrhc_parser #(
      .MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTE_LIMIT(HEADER_BYTE_LIMIT)
   ) u_parser (
      .clock, .reset,
      .word(pop_word), .word_valid(!empty), .word_pop(pop),
      .pg_width(pg_width_ff), .pg_height(pg_height_ff),
      .out_word(vw), .out_valid(rsp_tvalid), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {2'b00, vw.sof_width, vw.height_field_offset,
                       vw.hdr_height, vw.status};
endmodule
`default_nettype wire

// ----- rtl/jrhc_checker.sv -----
// ----------------------------------------------------------------------------
// jrhc_checker: port-level checks
// Watch the top-level ports for verdict and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module jrhc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped or changed while stalled");
   a_height: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[15:2] == 14'd0)
      else $error("height given on a rejected file");
   a_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == 2'd1 |-> rsp_tdata[45:16] == 30'd0)
      else $error("frame fields given on a header reject");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:46] == 2'd0)
      else $error("padding not zero");
endmodule

bind jpeg_restart_height_checker jrhc_checker u_jrhc_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

// ----- tb/jpeg_restart_height_checker_test.sv -----
// ----------------------------------------------------------------------------
// jpeg_restart_height_checker_test: self-checking bench for the restart checker
// Streams whole JPEG-like files (well-formed ones with random content, broken
// ones, and noise) through the checker under random gaps and stalls on both
// sides, predicts each per-file verdict, and checks every rsp word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module jpeg_restart_height_checker_test;
   import jrhc_pkg::*;

   localparam int MAX_SEGMENTS      = 128;
   localparam int HEADER_BYTE_LIMIT = 65536;
   localparam int DRAIN_CYCLES      = 12;   // intake queue plus parser stage, with margin
   localparam int TARGET_BYTES      = 2000;

   typedef enum int {
      P_SOI0, P_SOI1, P_SEGFF, P_MARKER, P_LENHI, P_LENLO,
      P_PAYLOAD, P_ENTROPY, P_DRAIN, P_OK
   } parse_phase_type;

   // ways to build a file; only F_NONE is meant to pass
   typedef enum int {
      F_NONE, F_MUTATE, F_TRUNC, F_EXTRA, F_NO_DRI, F_BAD_DRI, F_TWO_SOF,
      F_BAD_RST, F_BAD_MARKER, F_ENT_MARKER, F_NOISE, F_SHORT_LEN, F_TOO_MANY,
      F_HUGE_APP
   } file_shape_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [0:0]   csr_index;
   logic [13:0]  csr_data;

   jpeg_restart_height_checker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // pending input words: {last, byte}
   logic [8:0]   file_bytes_q[$];
   verdict_type  verdict_q[$];
   int           bytes_queued;
   int           fail_count;
   bit           quiet;        // no gaps on either side
   bit           long_hold;    // ask the receiver for one long hold-off

   // ------------------------------------------------------------------------
   // Verdict predictor: a mirror of the checker's per-file state.
   // ------------------------------------------------------------------------
   logic [12:0]  page_w;
   logic [13:0]  page_h;
   parse_phase_type ph;
   int unsigned  pos, seg_cnt, cur_mk, seg_left, seg_idx;
   bit           sof_seen, dri_seen, in_prefix;
   int unsigned  dri_ivl, frame_w, frame_rows, height_ofs, rst_cnt, height_v;
   logic [1:0]   reject_code;
   logic [7:0]   hi_byte;

   function automatic void clear_file();
      ph = P_SOI0;
      pos = 0; seg_cnt = 0; cur_mk = 0; seg_left = 0; seg_idx = 0;
      sof_seen = 0; dri_seen = 0; in_prefix = 0;
      dri_ivl = 0; frame_w = 0; frame_rows = 0; height_ofs = 0;
      rst_cnt = 0; height_v = 0; reject_code = ST_OK; hi_byte = 0;
   endfunction

   function automatic void reject_file(logic [1:0] code);
      reject_code = code;
      ph = P_DRAIN;
   endfunction

   function automatic bit sof_byte_ok(int unsigned idx, logic [7:0] b, int unsigned p);
      int unsigned v;
      v = {hi_byte, b};
      case (idx)
         0: return b == 8'd8;
         1: begin
            if (p >= POS_SAT) return 0;
            height_ofs = p;
            hi_byte = b;
            return 1;
         end
         2: begin
            if (v != 4200 && v != 8400) return 0;
            frame_rows = v;
            return 1;
         end
         3: begin
            hi_byte = b;
            return 1;
         end
         4: begin
            if (!((v == 2550 && frame_rows == 4200) || (v == 5100 && frame_rows == 8400)))
               return 0;
            frame_w = v;
            return 1;
         end
         5, 12: return b == 8'd3;
         6: return b == 8'd1;
         7: return b == 8'h21;
         9: return b == 8'd2;
         10, 13: return b == 8'h11;
         default: return 1;
      endcase
   endfunction

   function automatic void segment_end();
      if (cur_mk == MK_SOF0) sof_seen = 1;
      if (cur_mk == MK_DRI) dri_seen = 1;
      if (cur_mk != MK_SOS) begin
         ph = P_SEGFF;
      end else if (!sof_seen || !dri_seen || dri_ivl != (frame_w + 15) / 16) begin
         reject_file(ST_HEADER);
      end else if (page_w == 0 || page_w > 5100 || page_h == 0 || page_h > 8400 ||
                   page_w > frame_w || page_h > frame_rows) begin
         reject_file(ST_PAGE);
      end else begin
         ph = P_ENTROPY;
         rst_cnt = 0;
         in_prefix = 0;
      end
   endfunction

   function automatic void entropy_byte(logic [7:0] b, bit last);
      int unsigned h, diff;
      if (!in_prefix) begin
         in_prefix = (b == MK_FF);
         return;
      end
      if (b == MK_FF) return;
      in_prefix = 0;
      if (b == 8'h00) return;
      if (b >= MK_RST0 && b <= MK_RST0 + 7) begin
         if (rst_cnt >= frame_rows / 8 || (b - MK_RST0) != (rst_cnt & 7))
            reject_file(ST_ENTROPY);
         else
            rst_cnt = (rst_cnt + 1) & 'h7FF;
         return;
      end
      if (b == MK_EOI && last) begin
         h = (rst_cnt + 1) * 8;
         diff = (h > page_h) ? h - page_h : page_h - h;
         if (h > frame_rows || diff > 8) begin
            reject_file(ST_ENTROPY);
         end else begin
            height_v = h;
            ph = P_OK;
         end
         return;
      end
      reject_file(ST_ENTROPY);
   endfunction

   function automatic void header_byte(logic [7:0] b, int unsigned p);
      int unsigned len;
      case (ph)
         P_SOI0: if (b == MK_FF) ph = P_SOI1; else reject_file(ST_HEADER);
         P_SOI1: if (b == MK_SOI) ph = P_SEGFF; else reject_file(ST_HEADER);
         P_SEGFF: begin
            if (seg_cnt >= MAX_SEGMENTS || p > HEADER_BYTE_LIMIT || b != MK_FF) begin
               reject_file(ST_HEADER);
            end else begin
               seg_cnt = (seg_cnt + 1) & 'hFF;
               ph = P_MARKER;
            end
         end
         P_MARKER: begin
            if (b != MK_FF) begin
               if (b == 8'h00 || b == MK_SOI || b == MK_EOI ||
                   (b >= MK_RST0 && b <= MK_RST0 + 7)) begin
                  reject_file(ST_HEADER);
               end else begin
                  cur_mk = b;
                  ph = P_LENHI;
               end
            end
         end
         P_LENHI: begin
            hi_byte = b;
            ph = P_LENLO;
         end
         P_LENLO: begin
            len = {hi_byte, b};
            if (len < 2 || (cur_mk == MK_SOF0 && (sof_seen || len != 17)) ||
                (cur_mk == MK_DRI && (dri_seen || len != 4))) begin
               reject_file(ST_HEADER);
            end else begin
               seg_left = len - 2;
               seg_idx = 0;
               if (seg_left == 0) segment_end(); else ph = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            if (cur_mk == MK_SOF0 && !sof_byte_ok(seg_idx, b, p)) begin
               reject_file(ST_HEADER);
            end else begin
               if (cur_mk == MK_DRI) begin
                  if (seg_idx == 0) hi_byte = b;
                  else dri_ivl = {hi_byte, b};
               end
               seg_left = (seg_left - 1) & 'hFFFF;
               if (seg_idx < 15) seg_idx++;
               if (seg_left == 0) segment_end();
            end
         end
         default: reject_file(ST_HEADER);
      endcase
   endfunction

   // advance the mirror by one accepted byte; queue a verdict on the final one
   function automatic void predict_byte(logic [7:0] b, bit last);
      int unsigned p;
      verdict_type v;
      p = pos;
      if (pos < POS_SAT) pos++;
      if (ph == P_ENTROPY) entropy_byte(b, last);
      else if (ph == P_OK) reject_file(ST_ENTROPY);
      else if (ph != P_DRAIN) header_byte(b, p);
      if (last) begin
         if (ph == P_DRAIN) v.status = reject_code;
         else if (ph == P_OK) v.status = ST_OK;
         else if (ph == P_ENTROPY) v.status = ST_ENTROPY;
         else v.status = ST_HEADER;
         v.hdr_height          = (v.status == ST_OK) ? 14'(height_v) : '0;
         v.height_field_offset = (v.status != ST_HEADER) ? 17'(height_ofs) : '0;
         v.sof_width           = (v.status != ST_HEADER) ? 13'(frame_w) : '0;
         verdict_q.push_back(v);
         clear_file();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Gaps: mostly none or short, now and then long.
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Input driver: hold the word until accepted, then advance to the next one.
   int req_gap;
   always @(posedge clock) begin
      logic [8:0] w;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0 || file_bytes_q.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_tvalid <= 1'b0;
            end else begin
               w = file_bytes_q.pop_front();
               req_tdata  <= w[7:0];
               req_tlast  <= w[8];
               req_tvalid <= 1'b1;
               req_gap = pick_gap();
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked.
   int rsp_stall;
   int rsp_hold;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
         rsp_hold  = 0;
      end else begin
         if (long_hold) begin
            long_hold = 0;
            rsp_hold  = 600;
         end
         if (rsp_hold > 0) rsp_hold--;
         else if (rsp_stall > 0) rsp_stall--;
         else if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
         rsp_tready <= (rsp_hold == 0 && rsp_stall == 0);
      end
   end

   function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         fail_count++;
      end
   endfunction

   // Result monitor: compare each verdict word with the oldest prediction.
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict word, expected none, actual %h", $time,
                     rsp_tdata);
            fail_count++;
         end else begin
            v = verdict_q.pop_front();
            check_field("status", v.status, rsp_tdata[1:0]);
            check_field("hdr_height", v.hdr_height, rsp_tdata[15:2]);
            check_field("height_field_offset", v.height_field_offset, rsp_tdata[32:16]);
            check_field("sof_width", v.sof_width, rsp_tdata[45:33]);
         end
      end
   end

   // Register mirror: update on each accepted write.
   always @(posedge clock) begin
      if (reset) begin
         page_w = 0;
         page_h = 0;
         clear_file();
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PAGE_WIDTH) page_w = csr_data[12:0];
         else page_h = csr_data;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [0:0] idx, logic [13:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // entropy-coded filler: random bytes with 0xFF stuffed
   function automatic void add_scan_data(ref logic [7:0] fq[$]);
      int r;
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 255);
         fq.push_back(8'(r));
         if (r == 255) fq.push_back(8'h00);
      end
   endfunction

   function automatic void add_sof(ref logic [7:0] fq[$], logic [15:0] h, logic [15:0] w);
      fq = {fq, MK_FF, MK_SOF0, 8'h00, 8'd17, 8'd8, h[15:8], h[7:0], w[15:8], w[7:0],
            8'd3, 8'd1, 8'h21, 8'($urandom_range(0, 3)), 8'd2, 8'h11,
            8'($urandom_range(0, 3)), 8'd3, 8'h11, 8'($urandom_range(0, 3))};
   endfunction

   // build one file and queue its words, last flag on the final byte
   task automatic send_file(bit wide, int restarts, file_shape_type shape);
      logic [7:0]  fq[$];
      logic [15:0] w, h, ivl;
      int          n;
      w   = wide ? 16'd5100 : 16'd2550;
      h   = wide ? 16'd8400 : 16'd4200;
      ivl = (w + 16'd15) / 16'd16 + ((shape == F_BAD_DRI) ? 16'd1 : 16'd0);
      fq  = {MK_FF, MK_SOI};
      if (shape == F_TOO_MANY) repeat (MAX_SEGMENTS + 1) fq = {fq, MK_FF, 8'hE1, 8'h00, 8'h02};
      if (shape == F_HUGE_APP) begin
         fq = {fq, MK_FF, 8'hE1, 8'hFF, 8'hFF};
         repeat (65533) fq.push_back(8'($urandom));
      end
      if ($urandom_range(0, 2) == 0) begin
         // application segment, with a fill byte before its marker
         n  = $urandom_range(0, 6);
         fq = {fq, MK_FF, MK_FF, 8'hE0, 8'h00, 8'(n + 2)};
         repeat (n) fq.push_back(8'($urandom));
      end
      if (shape == F_SHORT_LEN) fq = {fq, MK_FF, 8'hE2, 8'h00, 8'($urandom_range(0, 1))};
      if (shape == F_BAD_MARKER) begin
         case ($urandom_range(0, 3))
            0: fq = {fq, MK_FF, 8'h00};
            1: fq = {fq, MK_FF, MK_SOI};
            2: fq = {fq, MK_FF, MK_EOI};
            default: fq = {fq, MK_FF, 8'(MK_RST0 + $urandom_range(0, 7))};
         endcase
      end
      add_sof(fq, h, w);
      if (shape == F_TWO_SOF) add_sof(fq, h, w);
      if (shape != F_NO_DRI) fq = {fq, MK_FF, MK_DRI, 8'h00, 8'h04, ivl[15:8], ivl[7:0]};
      n  = $urandom_range(0, 4);
      fq = {fq, MK_FF, MK_SOS, 8'h00, 8'(n + 2)};
      repeat (n) fq.push_back(8'($urandom));
      for (int k = 0; k < restarts; k++) begin
         add_scan_data(fq);
         fq.push_back(MK_FF);
         if ($urandom_range(0, 7) == 0) fq.push_back(MK_FF);
         if (shape == F_BAD_RST && k == restarts - 1) fq.push_back(8'(MK_RST0 + ((k + 1) % 8)));
         else fq.push_back(8'(MK_RST0 + (k % 8)));
      end
      add_scan_data(fq);
      if (shape == F_ENT_MARKER) fq = {fq, MK_FF, 8'(8'hC1 + $urandom_range(0, 12))};
      fq = {fq, MK_FF, MK_EOI};
      if (shape == F_EXTRA) fq.push_back(8'($urandom));
      if (shape == F_MUTATE) fq[$urandom_range(0, fq.size() - 1)] = 8'($urandom);
      if (shape == F_TRUNC) fq = fq[0:$urandom_range(0, fq.size() - 2)];
      if (shape == F_NOISE) begin
         fq.delete();
         repeat ($urandom_range(1, 20)) fq.push_back(8'($urandom));
      end
      foreach (fq[i]) file_bytes_q.push_back({i == fq.size() - 1, fq[i]});
      bytes_queued += fq.size();
   endtask

   // restart count that lands near the page height, sometimes just off it
   function automatic int restarts_for(int height);
      int r;
      r = height / 8 - 1 + $urandom_range(0, 2) - 1;
      return (r < 0) ? 0 : r;
   endfunction

   task automatic wait_idle();
      while (file_bytes_q.size() != 0 || req_tvalid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_page(int pw, int ph_rows, int files, bit wide);
      file_shape_type shape;
      int          r;
      csr_write(CSR_PAGE_WIDTH, 14'(pw));
      csr_write(CSR_PAGE_HEIGHT, 14'(ph_rows));
      repeat (files) begin
         r = $urandom_range(0, 99);
         if (r < 70) shape = F_NONE;
         else if (r < 82) shape = F_MUTATE;
         else shape = file_shape_type'($urandom_range(F_TRUNC, F_SHORT_LEN));
         send_file(wide || $urandom_range(0, 1), restarts_for(ph_rows), shape);
      end
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      fail_count = 0;
      bytes_queued = 0;
      quiet      = 0;
      long_hold  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: registers still at reset, so even a clean file is a page reject
      send_file(0, 1, F_NONE);
      send_file(0, 0, F_NOISE);
      wait_idle();

      csr_write(CSR_PAGE_WIDTH, 14'd2550);
      csr_write(CSR_PAGE_HEIGHT, 14'd24);
      send_file(0, 2, F_NONE);
      send_file(1, 2, F_NONE);
      for (int s = F_MUTATE; s <= F_TOO_MANY; s++) send_file(0, 2, file_shape_type'(s));
      send_file(0, 3, F_NONE);     // height one row of blocks above the page
      send_file(0, 4, F_NONE);     // and one step further: entropy reject
      wait_idle();

      // extremes of the page registers; the tall page needs over 500 restarts
      run_page(5100, 64, 1, 1);
      run_page(2550, 4200, 1, 0);
      run_page(1, 8, 2, 0);
      run_page(0, 40, 1, 0);
      run_page(5101, 40, 1, 0);
      run_page(2551, 40, 1, 0);
      run_page(100, 0, 1, 0);
      run_page(100, 4201, 1, 0);
      run_page(8191, 16383, 1, 0);

      // receiver holds off while short files keep coming in
      csr_write(CSR_PAGE_WIDTH, 14'd1000);
      csr_write(CSR_PAGE_HEIGHT, 14'd8);
      long_hold = 1;
      repeat (8) send_file($urandom_range(0, 1), $urandom_range(0, 1), F_NONE);
      wait_idle();

      // random settings, mostly small pages so files stay short
      while (bytes_queued < TARGET_BYTES + 2500) begin
         quiet = ($urandom_range(0, 4) == 0);
         run_page($urandom_range(1, 5100), $urandom_range(1, 200), $urandom_range(2, 6), 0);
      end

      if (fail_count == 0) $display("[jpeg_restart_height_checker] OK");
      else $display("[jpeg_restart_height_checker] ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("[jpeg_restart_height_checker] ERROR");
      $finish;
   end

endmodule

// ----- jpeg_restart_height_checker.f -----
rtl/jrhc_pkg.sv
rtl/jrhc_front.sv
rtl/jrhc_fifo.sv
rtl/jrhc_parser.sv
rtl/jpeg_restart_height_checker.sv
rtl/jrhc_checker.sv
tb/jpeg_restart_height_checker_test.sv
